[rtl/core/itrd_pkg.sv]
package itrd_pkg;

    // Field widths of the input and result items.
    localparam int VALUE_BITS  = 32;
    localparam int RADIX_BITS  = 6;
    localparam int CHAR_BITS   = 7;
    localparam int STATUS_BITS = 2;

    // Digit buffer depth and derived widths.
    localparam int MAX_DIGITS  = 31;
    localparam int QUOT_BITS   = VALUE_BITS - 1;
    localparam int DIGIT_BITS  = RADIX_BITS;
    localparam int IDX_BITS    = $clog2(MAX_DIGITS);
    localparam int COUNT_BITS  = $clog2(MAX_DIGITS + 1);
    localparam int STEP_BITS   = $clog2(QUOT_BITS);

    // Stream data widths, padded to whole bytes.
    localparam int IN_DATA_BITS  = ((VALUE_BITS + RADIX_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((CHAR_BITS + 7) / 8) * 8;

    // Accepted range of the base.
    localparam logic [RADIX_BITS-1:0] MIN_RADIX = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] MAX_RADIX = RADIX_BITS'(36);

    // Character mapping.
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = CHAR_BITS'(8'h30);
    localparam logic [CHAR_BITS-1:0] CHAR_A     = CHAR_BITS'(8'h61);
    localparam logic [CHAR_BITS-1:0] CHAR_NONE  = '0;
    localparam int                   DEC_DIGITS = 10;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_OK       = STATUS_BITS'(0);
    localparam logic [STATUS_BITS-1:0] STATUS_BAD_BASE = STATUS_BITS'(1);
    localparam logic [STATUS_BITS-1:0] STATUS_NEGATIVE = STATUS_BITS'(2);

    // Request to the shared divider.
    typedef struct packed {
        logic                  start;
        logic [QUOT_BITS-1:0]  dividend;
        logic [DIGIT_BITS-1:0] divisor;
    } div_req_t;

    // Status and result of the shared divider.
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [QUOT_BITS-1:0]  quotient;
        logic [DIGIT_BITS-1:0] remainder;
    } div_res_t;

    // Digits 0 to 9 become '0' to '9', digits 10 to 35 become 'a' to 'z'.
    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        if (d < DIGIT_BITS'(DEC_DIGITS))
        begin
            return CHAR_ZERO + CHAR_BITS'(d);
        end
        return CHAR_A + CHAR_BITS'(d) - CHAR_BITS'(DEC_DIGITS);
    endfunction

endpackage

[rtl/core/itrd_divider.sv]
module itrd_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  itrd_pkg::div_req_t req,
    output itrd_pkg::div_res_t res
);
    import itrd_pkg::*;

    logic [QUOT_BITS-1:0]  quot_reg;
    logic [DIGIT_BITS-1:0] rem_reg;
    logic [DIGIT_BITS-1:0] divisor_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIGIT_BITS:0]   trial;
    logic                  fits;
    logic [DIGIT_BITS-1:0] rem_step;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, quot_reg[QUOT_BITS-1]};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_step = fits ? DIGIT_BITS'(trial - {1'b0, divisor_reg})
                        : trial[DIGIT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(QUOT_BITS - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_BITS'(1);
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[QUOT_BITS-2:0], fits};
            rem_reg  <= rem_step;
        end
    end

    assign res.busy      = busy_reg;
    assign res.done      = done_reg;
    assign res.quotient  = quot_reg;
    assign res.remainder = rem_reg;

endmodule

[rtl/core/integer_to_radix_digits_unit.sv]
// Channel   | Direction | Signals                          | Contents
// s_axis    | in        | tvalid, tready, tdata[39:0]      | value [31:0], radix [37:32]
// m_axis    | out       | tvalid, tready, tdata[7:0],      | digit_char [6:0];
//           |           | tuser[1:0], tlast                | tuser status, tlast last
//
// Each division by the base runs on the shared bit-serial divider, which
// produces its 31 quotient bits, one per cycle, and then hands the result back.
// A value with n digits takes n divisions, and each emitted digit passes through
// a buffer read state and an output state; base 2 gives at most 31 digits.
// Bad bases, negative values and zero give one result from a single-result state.
// The input is ready only when the sequencer is idle; it can take the next
// transaction while the final result still sits in the output register.
// Stalls on the output hold the sequencer. rst_n clears all control.
module integer_to_radix_digits_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // value [31:0], radix [37:32], zero fill [39:38]
    input  logic [itrd_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // digit_char [6:0], zero fill [7]
    output logic [itrd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    // status [1:0]
    output logic [itrd_pkg::STATUS_BITS-1:0]   m_axis_tuser,
    output logic                               m_axis_tlast
);
    import itrd_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DIV      = 3'd1;
    localparam logic [2:0] S_EMIT_RD  = 3'd2;
    localparam logic [2:0] S_EMIT_OUT = 3'd3;
    localparam logic [2:0] S_SINGLE   = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [RADIX_BITS-1:0]  base_reg, base_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [IDX_BITS-1:0]    rd_idx_reg, rd_idx_next;
    logic [CHAR_BITS-1:0]   single_char_reg, single_char_next;
    logic [STATUS_BITS-1:0] single_status_reg, single_status_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0]   out_char_reg, out_char_next;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic                   out_last_reg, out_last_next;

    // Digit buffer, least significant digit at entry zero.
    logic [DIGIT_BITS-1:0]  store_mem [MAX_DIGITS];
    logic [DIGIT_BITS-1:0]  rd_data_reg;
    logic                   wr_en;

    logic [VALUE_BITS-1:0]  in_value;
    logic [RADIX_BITS-1:0]  in_radix;
    logic                   in_accept;
    logic                   out_free;
    logic [COUNT_BITS-1:0]  count_inc;

    div_req_t               div_req;
    div_res_t               div_res;

    itrd_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign in_value      = s_axis_tdata[VALUE_BITS-1:0];
    assign in_radix      = s_axis_tdata[VALUE_BITS +: RADIX_BITS];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Digits beyond the buffer depth are dropped, keeping the low-order ones.
    assign count_inc = (count_reg < COUNT_BITS'(MAX_DIGITS)) ? count_reg + COUNT_BITS'(1)
                                                             : count_reg;

    always_comb
    begin
        state_next         = state_reg;
        base_next          = base_reg;
        count_next         = count_reg;
        rd_idx_next        = rd_idx_reg;
        single_char_next   = single_char_reg;
        single_status_next = single_status_reg;
        out_valid_next     = out_valid_reg && !m_axis_tready;
        out_char_next      = out_char_reg;
        out_status_next    = out_status_reg;
        out_last_next      = out_last_reg;
        wr_en              = 1'b0;

        div_req.start      = 1'b0;
        div_req.dividend   = div_res.quotient;
        div_req.divisor    = base_reg;

        case (state_reg)
            S_IDLE:
            begin
                div_req.dividend = in_value[QUOT_BITS-1:0];
                div_req.divisor  = in_radix;
                if (in_accept)
                begin
                    base_next  = in_radix;
                    count_next = '0;
                    if (!(in_radix inside {[MIN_RADIX:MAX_RADIX]}))
                    begin
                        // The base check takes precedence over the sign.
                        single_char_next   = CHAR_NONE;
                        single_status_next = STATUS_BAD_BASE;
                        state_next         = S_SINGLE;
                    end
                    else if (in_value[VALUE_BITS-1])
                    begin
                        single_char_next   = CHAR_NONE;
                        single_status_next = STATUS_NEGATIVE;
                        state_next         = S_SINGLE;
                    end
                    else if (in_value == '0)
                    begin
                        single_char_next   = CHAR_ZERO;
                        single_status_next = STATUS_OK;
                        state_next         = S_SINGLE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (div_res.done)
                begin
                    wr_en      = (count_reg < COUNT_BITS'(MAX_DIGITS));
                    count_next = count_inc;
                    if (div_res.quotient == '0)
                    begin
                        // Emission starts at the most significant digit.
                        rd_idx_next = IDX_BITS'(count_inc - COUNT_BITS'(1));
                        state_next  = S_EMIT_RD;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                    end
                end
            end

            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end

            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = digit_to_ascii(rd_data_reg);
                    out_status_next = STATUS_OK;
                    out_last_next   = (rd_idx_reg == '0);
                    if (rd_idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - IDX_BITS'(1);
                        state_next  = S_EMIT_RD;
                    end
                end
            end

            S_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = single_char_reg;
                    out_status_next = single_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg          <= base_next;
        rd_idx_reg        <= rd_idx_next;
        single_char_reg   <= single_char_next;
        single_status_reg <= single_status_next;
        out_char_reg      <= out_char_next;
        out_status_reg    <= out_status_next;
        out_last_reg      <= out_last_next;
    end

    // Digit buffer: one write port fed by the divider, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[count_reg[IDX_BITS-1:0]] <= div_res.remainder;
        end
        rd_data_reg <= store_mem[rd_idx_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS - CHAR_BITS){1'b0}}, out_char_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // The divider only runs while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_res.busy || div_res.done) |-> (state_reg == S_DIV))
    else $error("divider active outside the division state");

    // The digit count never runs past the buffer depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(MAX_DIGITS))
    else $error("digit count exceeds buffer depth");

    // An error result carries no character and closes its input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |->
            (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("error result with a character or without last");

    // A new transaction is only taken while no division is in flight, and emission never follows it directly.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != S_EMIT_RD) && (state_reg != S_EMIT_OUT))
    else $error("emission started directly after an accepted transaction");

endmodule
